### rtl/nlp_pkg.sv
// Package for the next lexicographic permutation unit.
// Holds sizing constants, element and array types, and the request/response structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nlp_pkg;

    localparam int NUM_ELEMS  = 8;
    localparam int ELEM_WIDTH = 32;
    localparam int IDX_W      = $clog2(NUM_ELEMS);

    typedef logic signed [ELEM_WIDTH-1:0] t_elem;
    typedef t_elem [NUM_ELEMS-1:0]        t_elem_arr;
    typedef logic [IDX_W-1:0]             t_idx;
    typedef logic [NUM_ELEMS-2:0]         t_asc;

    // Input request: one whole array
    typedef struct packed {
        logic signed [ELEM_WIDTH-1:0] elem_in_7;
        logic signed [ELEM_WIDTH-1:0] elem_in_6;
        logic signed [ELEM_WIDTH-1:0] elem_in_5;
        logic signed [ELEM_WIDTH-1:0] elem_in_4;
        logic signed [ELEM_WIDTH-1:0] elem_in_3;
        logic signed [ELEM_WIDTH-1:0] elem_in_2;
        logic signed [ELEM_WIDTH-1:0] elem_in_1;
        logic signed [ELEM_WIDTH-1:0] elem_in_0;
    } t_in_item;

    // Output response: next permutation plus flag
    typedef struct packed {
        logic signed [ELEM_WIDTH-1:0] elem_out_7;
        logic signed [ELEM_WIDTH-1:0] elem_out_6;
        logic signed [ELEM_WIDTH-1:0] elem_out_5;
        logic signed [ELEM_WIDTH-1:0] elem_out_4;
        logic signed [ELEM_WIDTH-1:0] elem_out_3;
        logic signed [ELEM_WIDTH-1:0] elem_out_2;
        logic signed [ELEM_WIDTH-1:0] elem_out_1;
        logic signed [ELEM_WIDTH-1:0] elem_out_0;
        logic                         has_next;
    } t_out_item;

endpackage

`default_nettype wire

### rtl/nlp_ascent.sv
// Stage 1: neighbor compares, one ascent bit per adjacent pair.
// Depends on nlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nlp_ascent (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire nlp_pkg::t_elem_arr i_elems,
    output nlp_pkg::t_elem_arr     o_elems,
    output nlp_pkg::t_asc          o_asc
);

    nlp_pkg::t_elem_arr r_elems;
    nlp_pkg::t_asc      r_asc;
    nlp_pkg::t_asc      n_asc;

    // Ascent where left element is strictly below its right neighbor
    always_comb begin
        for (int i = 0; i < nlp_pkg::NUM_ELEMS - 1; i++) begin
            n_asc[i] = $signed(i_elems[i]) < $signed(i_elems[i+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_elems <= i_elems;
            r_asc   <= n_asc;
        end
    end

    assign o_elems = r_elems;
    assign o_asc   = r_asc;

endmodule

`default_nettype wire

### rtl/nlp_pivot.sv
// Stage 2: picks the rightmost ascent as pivot and latches the pivot value.
// Depends on nlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nlp_pivot (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire nlp_pkg::t_elem_arr i_elems,
    input  wire nlp_pkg::t_asc      i_asc,
    output nlp_pkg::t_elem_arr      o_elems,
    output nlp_pkg::t_idx           o_piv,
    output nlp_pkg::t_elem          o_piv_val,
    output logic                    o_found
);

    nlp_pkg::t_elem_arr r_elems;
    nlp_pkg::t_idx      r_piv;
    nlp_pkg::t_elem     r_piv_val;
    logic               r_found;
    nlp_pkg::t_idx      n_piv;

    // Priority encode: later hits override, so the highest ascent wins
    always_comb begin
        n_piv = '0;
        for (int i = 0; i < nlp_pkg::NUM_ELEMS - 1; i++) begin
            if (i_asc[i]) begin
                n_piv = nlp_pkg::IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_elems   <= i_elems;
            r_piv     <= n_piv;
            r_piv_val <= i_elems[n_piv];
            r_found   <= |i_asc;
        end
    end

    assign o_elems   = r_elems;
    assign o_piv     = r_piv;
    assign o_piv_val = r_piv_val;
    assign o_found   = r_found;

endmodule

`default_nettype wire

### rtl/nlp_succ.sv
// Stage 3: finds the rightmost element right of the pivot that exceeds it.
// Depends on nlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nlp_succ (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire nlp_pkg::t_elem_arr i_elems,
    input  wire nlp_pkg::t_idx      i_piv,
    input  wire nlp_pkg::t_elem     i_piv_val,
    input  wire logic               i_found,
    output nlp_pkg::t_elem_arr      o_elems,
    output nlp_pkg::t_idx           o_piv,
    output nlp_pkg::t_idx           o_succ,
    output logic                    o_found
);

    nlp_pkg::t_elem_arr r_elems;
    nlp_pkg::t_idx      r_piv;
    nlp_pkg::t_idx      r_succ;
    logic               r_found;
    nlp_pkg::t_idx      n_succ;

    // Independent compares against the pivot, highest hit wins
    always_comb begin
        n_succ = '0;
        for (int j = 1; j < nlp_pkg::NUM_ELEMS; j++) begin
            if ((nlp_pkg::IDX_W'(j) > i_piv) && ($signed(i_elems[j]) > $signed(i_piv_val))) begin
                n_succ = nlp_pkg::IDX_W'(j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_elems <= i_elems;
            r_piv   <= i_piv;
            r_succ  <= n_succ;
            r_found <= i_found;
        end
    end

    assign o_elems = r_elems;
    assign o_piv   = r_piv;
    assign o_succ  = r_succ;
    assign o_found = r_found;

endmodule

`default_nettype wire

### rtl/nlp_permute.sv
// Stage 4: swap pivot with successor and reverse the suffix, as one output mux per slot.
// Depends on nlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nlp_permute (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire nlp_pkg::t_elem_arr i_elems,
    input  wire nlp_pkg::t_idx      i_piv,
    input  wire nlp_pkg::t_idx      i_succ,
    input  wire logic               i_found,
    output nlp_pkg::t_elem_arr      o_elems,
    output logic                    o_has_next
);

    nlp_pkg::t_elem_arr r_elems;
    logic               r_has_next;
    nlp_pkg::t_elem_arr n_elems;

    // Slot k > pivot takes its mirror; the successor's mirror slot takes the old pivot
    always_comb begin
        logic [nlp_pkg::IDX_W:0] src_w;
        nlp_pkg::t_idx           src;
        for (int k = 0; k < nlp_pkg::NUM_ELEMS; k++) begin
            src_w = (nlp_pkg::IDX_W+1)'(nlp_pkg::NUM_ELEMS) + {1'b0, i_piv}
                    - (nlp_pkg::IDX_W+1)'(k);
            src   = src_w[nlp_pkg::IDX_W-1:0];
            if (!i_found || (nlp_pkg::IDX_W'(k) < i_piv)) begin
                n_elems[k] = i_elems[k];
            end else if (nlp_pkg::IDX_W'(k) == i_piv) begin
                n_elems[k] = i_elems[i_succ];
            end else if (src == i_succ) begin
                n_elems[k] = i_elems[i_piv];
            end else begin
                n_elems[k] = i_elems[src];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_elems    <= n_elems;
            r_has_next <= i_found;
        end
    end

    assign o_elems    = r_elems;
    assign o_has_next = r_has_next;

endmodule

`default_nettype wire

### rtl/next_lex_permutation_unit.sv
// Next lexicographic permutation unit: four register stages.
// The four-stage datapath sets the latency; o_rsp_valid is the permute stage's valid bit.
// Throughput: one request per cycle while o_req_stall is low.
// Stalls ripple back stage by stage; empty stages keep filling while the output waits.
// Reset (synchronous, active low) clears the stage valid bits only.
// Depends on nlp_pkg, nlp_ascent, nlp_pivot, nlp_succ, nlp_permute.
`timescale 1ns / 1ps
`default_nettype none

module next_lex_permutation_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    input  wire nlp_pkg::t_in_item i_req,
    output logic                   o_req_stall,
    output logic                   o_rsp_valid,
    output nlp_pkg::t_out_item     o_rsp,
    input  wire logic              i_rsp_stall
);

    nlp_pkg::t_elem_arr in_elems;
    nlp_pkg::t_elem_arr s1_elems, s2_elems, s3_elems, s4_elems;
    nlp_pkg::t_asc      s1_asc;
    nlp_pkg::t_idx      s2_piv, s3_piv, s3_succ;
    nlp_pkg::t_elem     s2_piv_val;
    logic               s2_found, s3_found, s4_has_next;

    logic [4:1] r_vld;
    logic [4:1] n_vld;
    logic [5:1] adv;

    // Unpack request fields into an indexed array
    assign in_elems[0] = i_req.elem_in_0;
    assign in_elems[1] = i_req.elem_in_1;
    assign in_elems[2] = i_req.elem_in_2;
    assign in_elems[3] = i_req.elem_in_3;
    assign in_elems[4] = i_req.elem_in_4;
    assign in_elems[5] = i_req.elem_in_5;
    assign in_elems[6] = i_req.elem_in_6;
    assign in_elems[7] = i_req.elem_in_7;

    // Stage advance: a stage loads when empty or when its contents move on
    always_comb begin
        adv[5] = !i_rsp_stall;
        for (int k = 4; k >= 1; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    always_comb begin
        n_vld[1] = adv[1] ? i_req_valid : r_vld[1];
        for (int k = 2; k <= 4; k++) begin
            n_vld[k] = adv[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    nlp_ascent u_ascent (
        .i_clk   (i_clk),
        .i_en    (adv[1]),
        .i_elems (in_elems),
        .o_elems (s1_elems),
        .o_asc   (s1_asc)
    );

    nlp_pivot u_pivot (
        .i_clk     (i_clk),
        .i_en      (adv[2]),
        .i_elems   (s1_elems),
        .i_asc     (s1_asc),
        .o_elems   (s2_elems),
        .o_piv     (s2_piv),
        .o_piv_val (s2_piv_val),
        .o_found   (s2_found)
    );

    nlp_succ u_succ (
        .i_clk     (i_clk),
        .i_en      (adv[3]),
        .i_elems   (s2_elems),
        .i_piv     (s2_piv),
        .i_piv_val (s2_piv_val),
        .i_found   (s2_found),
        .o_elems   (s3_elems),
        .o_piv     (s3_piv),
        .o_succ    (s3_succ),
        .o_found   (s3_found)
    );

    nlp_permute u_permute (
        .i_clk      (i_clk),
        .i_en       (adv[4]),
        .i_elems    (s3_elems),
        .i_piv      (s3_piv),
        .i_succ     (s3_succ),
        .i_found    (s3_found),
        .o_elems    (s4_elems),
        .o_has_next (s4_has_next)
    );

    // Response packing
    assign o_req_stall      = !adv[1];
    assign o_rsp_valid      = r_vld[4];
    assign o_rsp.elem_out_0 = s4_elems[0];
    assign o_rsp.elem_out_1 = s4_elems[1];
    assign o_rsp.elem_out_2 = s4_elems[2];
    assign o_rsp.elem_out_3 = s4_elems[3];
    assign o_rsp.elem_out_4 = s4_elems[4];
    assign o_rsp.elem_out_5 = s4_elems[5];
    assign o_rsp.elem_out_6 = s4_elems[6];
    assign o_rsp.elem_out_7 = s4_elems[7];
    assign o_rsp.has_next   = s4_has_next;

endmodule

`default_nettype wire

### rtl/nlp_checker.sv
// Port-level checks for the next lexicographic permutation unit, bound to the top level.
// Depends on nlp_pkg and next_lex_permutation_unit.
`timescale 1ns / 1ps
`default_nettype none

module nlp_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_req_valid,
    input wire logic               o_req_stall,
    input wire logic               o_rsp_valid,
    input wire nlp_pkg::t_out_item o_rsp,
    input wire logic               i_rsp_stall
);

    // A stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled response changed");

    // With a free output the pipeline never pushes back on requests
    a_no_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rsp_stall |-> !o_req_stall)
        else $error("request stalled while output free");

    // Last permutation: a response without successor is non-increasing
    a_last_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp.has_next |->
            ($signed(o_rsp.elem_out_0) >= $signed(o_rsp.elem_out_1)) &&
            ($signed(o_rsp.elem_out_1) >= $signed(o_rsp.elem_out_2)) &&
            ($signed(o_rsp.elem_out_2) >= $signed(o_rsp.elem_out_3)) &&
            ($signed(o_rsp.elem_out_3) >= $signed(o_rsp.elem_out_4)) &&
            ($signed(o_rsp.elem_out_4) >= $signed(o_rsp.elem_out_5)) &&
            ($signed(o_rsp.elem_out_5) >= $signed(o_rsp.elem_out_6)) &&
            ($signed(o_rsp.elem_out_6) >= $signed(o_rsp.elem_out_7)))
        else $error("no-successor response is not non-increasing");

    // An accepted request reaches the output if the output is not stalled while it moves through the stages
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && !o_req_stall) ##1 !i_rsp_stall ##1 !i_rsp_stall ##1 !i_rsp_stall
            |=> o_rsp_valid)
        else $error("response missing after pipeline latency");

endmodule

bind next_lex_permutation_unit nlp_checker u_nlp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_stall (o_req_stall),
    .o_rsp_valid (o_rsp_valid),
    .o_rsp       (o_rsp),
    .i_rsp_stall (i_rsp_stall)
);

`default_nettype wire
